@@ hw/rtl/avcc_pkg.sv @@
// Shared types and constants for the AVCC to Annex B NAL converter.
package avcc_pkg;

    // Width of one stream byte.
    localparam int BYTE_W = 8;

    // Width of the length prefix size register.
    localparam int CFG_W = 3;

    // Prefix size after reset, and the largest and smallest prefix sizes in bytes.
    localparam logic [CFG_W-1:0] CFG_RESET  = 3'd4;
    localparam logic [CFG_W-1:0] PREFIX_MAX = 3'd4;
    localparam logic [CFG_W-1:0] PREFIX_MIN = 3'd1;

    // Default depth of the command queue between the front and the back.
    localparam int DEF_QUEUE_DEPTH = 4;

    // Four-byte start code; the three-byte form is its last three bytes.
    localparam logic [BYTE_W-1:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

    // What the back end has to emit for one accepted input byte.
    typedef enum logic [1:0] {
        CMD_SC4  = 2'd0,   // four-byte start code
        CMD_SC3  = 2'd1,   // three-byte start code
        CMD_DATA = 2'd2,   // one payload byte, optionally followed by the end marker
        CMD_MARK = 2'd3    // end marker only
    } cmd_kind_t;

    // One queued command.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data;
        logic              mark;
        logic              trunc;
    } cmd_t;

endpackage

@@ hw/rtl/avcc_to_annexb_nal_convert_top.sv @@
// Results pass the command queue and then the back end output register.
// Throughput: one input byte per cycle while the command queue is not full;
// each start code expands into three or four output results, and the queue
// absorbs the input meanwhile. The output side sets the sustained rate: one
// result per cycle while m_tready is high. Reset (rst_n low, asynchronous)
// empties the queue, clears the parser and sets the prefix size to four bytes.
module avcc_to_annexb_nal_convert_top
    import avcc_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,   // length_field_bytes
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,     // [7:0] in_byte
    input  logic              s_tlast,     // last_in
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,     // [7:0] out_byte
    output logic              m_tlast,     // last_out
    output logic [1:0]        m_tuser      // [0] has_byte, [1] truncated
);

    logic [CFG_W-1:0] cfg_reg;
    logic             in_accept;
    logic             cmd_push;
    cmd_t             cmd;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    cmd_t             head_cmd;
    logic             has_byte;
    logic             truncated;

    // Prefix size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_we)
            cfg_reg <= cfg_wdata;
    end

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    avcc_front u_front
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .length_field_bytes (cfg_reg),
        .in_accept          (in_accept),
        .in_byte            (s_tdata),
        .last_in            (s_tlast),
        .cmd_push           (cmd_push),
        .cmd                (cmd)
    );

    avcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    avcc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .has_byte  (has_byte),
        .last_out  (m_tlast),
        .truncated (truncated)
    );

    assign m_tuser = {truncated, has_byte};

endmodule

@@ hw/rtl/avcc_front.sv @@
// Front end: parses length prefixes and payload runs and issues commands.
module avcc_front
    import avcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CFG_W-1:0]  length_field_bytes,
    input  logic              in_accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              last_in,
    output logic              cmd_push,
    output cmd_t              cmd
);

    logic        in_payload_reg, in_payload_next;
    logic [1:0]  prefix_count_reg, prefix_count_next;
    logic [31:0] length_accum_reg, length_accum_next;
    logic [31:0] payload_left_reg, payload_left_next;
    logic        first_nal_reg, first_nal_next;

    logic [CFG_W-1:0] prefix_size;
    logic [2:0]       count;
    logic [31:0]      accum_shift;
    logic [31:0]      left_dec;

    // Clamp the configured prefix size into the range 1 to 4.
    always_comb
    begin
        if (length_field_bytes == '0)
            prefix_size = PREFIX_MIN;
        else if (length_field_bytes > PREFIX_MAX)
            prefix_size = PREFIX_MAX;
        else
            prefix_size = length_field_bytes;
    end

    assign count       = {1'b0, prefix_count_reg} + 3'd1;
    assign accum_shift = {length_accum_reg[23:0], in_byte};
    assign left_dec    = payload_left_reg - 32'd1;

    // Classify the byte and work out the parser's next state.
    always_comb
    begin
        in_payload_next   = in_payload_reg;
        prefix_count_next = prefix_count_reg;
        length_accum_next = length_accum_reg;
        payload_left_next = payload_left_reg;
        first_nal_next    = first_nal_reg;
        cmd_push          = 1'b0;
        cmd.kind          = CMD_MARK;
        cmd.data          = in_byte;
        cmd.mark          = last_in;
        cmd.trunc         = 1'b0;

        if (in_accept)
        begin
            if (!in_payload_reg)
            begin
                if (count >= prefix_size)
                begin
                    prefix_count_next = 2'd0;
                    length_accum_next = 32'd0;
                    if (!last_in)
                    begin
                        cmd_push          = 1'b1;
                        cmd.kind          = first_nal_reg ? CMD_SC4 : CMD_SC3;
                        first_nal_next    = 1'b0;
                        payload_left_next = accum_shift;
                        in_payload_next   = (accum_shift != 32'd0);
                    end
                end
                else
                begin
                    prefix_count_next = count[1:0];
                    length_accum_next = accum_shift;
                end
                // A prefix that meets the packet end yields only the marker.
                if (last_in)
                begin
                    cmd_push = 1'b1;
                    cmd.kind = CMD_MARK;
                end
            end
            else
            begin
                cmd_push          = 1'b1;
                cmd.kind          = CMD_DATA;
                cmd.trunc         = last_in && (left_dec != 32'd0);
                payload_left_next = left_dec;
                in_payload_next   = (left_dec != 32'd0);
            end

            // Packet end returns the parser to its starting state.
            if (last_in)
            begin
                in_payload_next   = 1'b0;
                prefix_count_next = 2'd0;
                length_accum_next = 32'd0;
                payload_left_next = 32'd0;
                first_nal_next    = 1'b1;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg   <= 1'b0;
            prefix_count_reg <= 2'd0;
            length_accum_reg <= 32'd0;
            payload_left_reg <= 32'd0;
            first_nal_reg    <= 1'b1;
        end
        else
        begin
            in_payload_reg   <= in_payload_next;
            prefix_count_reg <= prefix_count_next;
            length_accum_reg <= length_accum_next;
            payload_left_reg <= payload_left_next;
            first_nal_reg    <= first_nal_next;
        end
    end

endmodule

@@ hw/rtl/avcc_queue.sv @@
// Small register queue of commands between the front and the back end.
module avcc_queue
    import avcc_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ hw/rtl/avcc_back.sv @@
// Back end: expands queued commands into output bytes and end markers.
module avcc_back
    import avcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              head_cmd,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              has_byte,
    output logic              last_out,
    output logic              truncated
);

    logic [1:0] sub_reg, sub_next;
    logic [1:0] last_sub;
    logic       load;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              has_reg, has_next;
    logic              last_reg, last_next;
    logic              trunc_reg, trunc_next;

    // Number of results per command, minus one.
    always_comb
    begin
        case (head_cmd.kind)
            CMD_SC4:  last_sub = 2'd3;
            CMD_SC3:  last_sub = 2'd2;
            CMD_DATA: last_sub = head_cmd.mark ? 2'd1 : 2'd0;
            CMD_MARK: last_sub = 2'd0;
            default:  last_sub = 2'd0;
        endcase
    end

    // The output register takes a new result when empty or being drained.
    assign load = !empty && (!valid_reg || out_ready);
    assign pop  = load && (sub_reg == last_sub);

    // Pick the result for the current step of the head command.
    always_comb
    begin
        sub_next   = sub_reg;
        valid_next = valid_reg && !out_ready;
        byte_next  = byte_reg;
        has_next   = has_reg;
        last_next  = last_reg;
        trunc_next = trunc_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sub_next   = (sub_reg == last_sub) ? 2'd0 : sub_reg + 2'd1;
            byte_next  = {BYTE_W{1'b0}};
            has_next   = 1'b1;
            last_next  = 1'b0;
            trunc_next = 1'b0;
            case (head_cmd.kind)
                CMD_SC4:
                begin
                    byte_next = START_CODE[sub_reg];
                end
                CMD_SC3:
                begin
                    byte_next = START_CODE[sub_reg + 2'd1];
                end
                CMD_DATA:
                begin
                    if (sub_reg == 2'd0)
                        byte_next = head_cmd.data;
                    else
                    begin
                        has_next   = 1'b0;
                        last_next  = 1'b1;
                        trunc_next = head_cmd.trunc;
                    end
                end
                default:
                begin
                    has_next   = 1'b0;
                    last_next  = 1'b1;
                    trunc_next = head_cmd.trunc;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        has_reg   <= has_next;
        last_reg  <= last_next;
        trunc_reg <= trunc_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign has_byte  = has_reg;
    assign last_out  = last_reg;
    assign truncated = trunc_reg;

endmodule

@@ tb/annexb_stream_checker.sv @@
// Checker that predicts the Annex B output stream and compares it with the block.
`timescale 1ns / 100ps

module annexb_stream_checker
    import avcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,     // [7:0] in_byte
    input  logic              s_tlast,     // last_in
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [BYTE_W-1:0] m_tdata,     // [7:0] out_byte
    input  logic              m_tlast,     // last_out
    input  logic [1:0]        m_tuser,     // [0] has_byte, [1] truncated
    output int                fail_count,
    output int                outstanding
);

    // One expected output request.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has_byte;
        logic              last;
        logic              trunc;
    } annexb_result_t;

    // Expected output requests, oldest first.
    annexb_result_t annexb_expected [$];

    // Shadow copy of the prefix size register and of the parser state.
    logic [CFG_W-1:0] prefix_cfg;
    logic             in_payload;
    logic [1:0]       prefix_cnt;
    logic [31:0]      len_acc;
    logic [31:0]      payload_left;
    logic             first_nal;

    // Prefix size in bytes; zero acts as one and anything past four as four.
    function automatic int unsigned prefix_bytes(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > PREFIX_MAX)
            return 32'(PREFIX_MAX);
        return 32'(v);
    endfunction

    task automatic push_result(input logic [BYTE_W-1:0] d, input logic h, input logic l,
                               input logic t);
        annexb_result_t r;
        r.data     = d;
        r.has_byte = h;
        r.last     = l;
        r.trunc    = t;
        annexb_expected.push_back(r);
    endtask

    task automatic clear_parser();
        in_payload   = 1'b0;
        prefix_cnt   = '0;
        len_acc      = '0;
        payload_left = '0;
        first_nal    = 1'b1;
    endtask

    // Work out the output requests caused by one accepted input byte.
    task automatic predict_annexb(input logic [BYTE_W-1:0] b, input logic last_byte);
        logic [2:0] count;
        logic       trunc;
        int         i;
        trunc = 1'b0;
        if (!in_payload) begin
            count   = {1'b0, prefix_cnt} + 3'd1;
            len_acc = {len_acc[23:0], b};
            if (count >= prefix_bytes(prefix_cfg)) begin
                prefix_cnt = '0;
                // A prefix that ends the packet produces no start code.
                if (!last_byte) begin
                    for (i = first_nal ? 0 : 1; i < 4; i++)
                        push_result(START_CODE[i], 1'b1, 1'b0, 1'b0);
                    first_nal    = 1'b0;
                    payload_left = len_acc;
                    in_payload   = (len_acc != '0);
                end
                len_acc = '0;
            end
            else begin
                prefix_cnt = count[1:0];
            end
        end
        else begin
            push_result(b, 1'b1, 1'b0, 1'b0);
            payload_left = payload_left - 32'd1;
            if (payload_left == '0)
                in_payload = 1'b0;
            if (last_byte && payload_left != '0)
                trunc = 1'b1;
        end
        // Every packet closes with a marker-only request.
        if (last_byte) begin
            push_result('0, 1'b0, 1'b1, trunc);
            clear_parser();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        fail_count++;
        $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Track register writes and input requests, then check output requests.
    always @(posedge clk or negedge rst_n)
    begin
        annexb_result_t want;
        if (!rst_n) begin
            prefix_cfg  = CFG_RESET;
            fail_count  = 0;
            annexb_expected.delete();
            clear_parser();
        end
        else begin
            if (cfg_we)
                prefix_cfg = cfg_wdata;
            if (s_tvalid && s_tready)
                predict_annexb(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (annexb_expected.size() == 0) begin
                    report_mismatch("unexpected output request", m_tdata, '0);
                end
                else begin
                    want = annexb_expected.pop_front();
                    if (m_tuser[0] !== want.has_byte)
                        report_mismatch("has_byte", BYTE_W'(m_tuser[0]),
                                        BYTE_W'(want.has_byte));
                    if (m_tdata !== want.data)
                        report_mismatch("out_byte", m_tdata, want.data);
                    if (m_tlast !== want.last)
                        report_mismatch("last_out", BYTE_W'(m_tlast), BYTE_W'(want.last));
                    if (m_tuser[1] !== want.trunc)
                        report_mismatch("truncated", BYTE_W'(m_tuser[1]),
                                        BYTE_W'(want.trunc));
                end
            end
        end
        outstanding = annexb_expected.size();
    end

endmodule

@@ tb/testbench.sv @@
// Testbench top: clock, reset, stimulus for the NAL converter and the final verdict.
`timescale 1ns / 100ps

module testbench;
    import avcc_pkg::*;

    // Cycles allowed for the pipeline to settle once nothing is expected.
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS  = 360;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;
    logic [1:0]        m_tuser;

    int               fail_count;
    int               outstanding;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               items_sent;
    logic [CFG_W-1:0] cur_cfg;

    avcc_to_annexb_nal_convert_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    annexb_stream_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    // Output side: stall at random according to the current phase.
    initial
    begin
        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one input request, with random idle cycles ahead of it.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_bytes(input logic [BYTE_W-1:0] seq [$], input logic ends_packet);
        foreach (seq[i])
            send_byte(seq[i], ends_packet && (i == seq.size() - 1));
    endtask

    // Hold the input until every expected request is out and the pipeline is quiet.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_prefix_size(input logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        cur_cfg    = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One packet: mostly well-formed NAL units, some cut short, some noise.
    task automatic send_random_packet();
        logic [BYTE_W-1:0] pkt [$];
        int unsigned       n;
        int unsigned       len;
        int unsigned       cut;
        int unsigned       kind;
        int                i;
        n    = (cur_cfg == '0) ? 1 : ((cur_cfg > PREFIX_MAX) ? PREFIX_MAX : cur_cfg);
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 6)) pkt.push_back(BYTE_W'($urandom));
        end
        else begin
            repeat ($urandom_range(1, 3)) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
                for (i = n - 1; i >= 0; i--)
                    pkt.push_back(BYTE_W'(len >> (8 * i)));
                repeat (len) pkt.push_back(BYTE_W'($urandom));
            end
            // Cut the packet at a random byte to hit broken prefixes and payloads.
            if (kind >= 70) begin
                cut = $urandom_range(1, pkt.size());
                while (pkt.size() > cut)
                    void'(pkt.pop_back());
            end
        end
        foreach (pkt[j]) begin
            if (j == pkt.size() / 2 && $urandom_range(39) == 0)
                wait_drained();
            send_byte(pkt[j], j == pkt.size() - 1);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [CFG_W-1:0] phase_cfg [8];
        int               target;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = CFG_RESET;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        cur_cfg        = CFG_RESET;
        phase_cfg      = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd1, 3'd6};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Four-byte prefixes: first and later start codes, byte extremes, a zero-length
        // unit, and a pause mid-payload until the output has caught up.
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h02, 8'hFF}, 1'b0);
        wait_drained();
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                     8'hA5}, 1'b1);

        // One-byte prefixes: a payload cut short, then a prefix on the last byte.
        wait_drained();
        write_prefix_size(3'd1);
        send_bytes('{8'h03, 8'h80, 8'h7F}, 1'b1);
        send_bytes('{8'h05}, 1'b1);

        // Prefix size shrinks while a prefix is half collected.
        wait_drained();
        write_prefix_size(3'd2);
        send_byte(8'h00, 1'b0);
        wait_drained();
        write_prefix_size(3'd1);
        send_bytes('{8'h01, 8'h42}, 1'b1);

        // Three-byte prefix dropped when the packet ends inside it.
        wait_drained();
        write_prefix_size(3'd3);
        send_bytes('{8'h00, 8'h01}, 1'b1);

        // Random packets over four idling phases, two prefix sizes each.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (int half = 0; half < 2; half++) begin
                wait_drained();
                write_prefix_size(phase_cfg[ph * 2 + half]);
                target = items_sent + RANDOM_ITEMS / 8;
                while (items_sent < target)
                    send_random_packet();
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog against a hung handshake or requests that never come.
    initial
    begin
        #(3_000_000);
        $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ avcc_to_annexb_nal_convert_top.f @@
hw/rtl/avcc_pkg.sv
hw/rtl/avcc_front.sv
hw/rtl/avcc_queue.sv
hw/rtl/avcc_back.sv
hw/rtl/avcc_to_annexb_nal_convert_top.sv
tb/annexb_stream_checker.sv
tb/testbench.sv
